/* rtl/can_node_id_allocation_server_top_defines.svh */
// Assertion macros for the node ID allocation server.
// Used by the controller and datapath modules; no other dependencies.
`ifndef CAN_NODE_ID_ALLOCATION_SERVER_TOP_DEFINES_SVH
`define CAN_NODE_ID_ALLOCATION_SERVER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define NIA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define NIA_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define NIA_ASSERT(label, clk, rst_n, prop)
`define NIA_ASSERT_NORST(label, clk, prop)
`endif
`endif

/* rtl/nidalloc_pkg.sv */
// Package for the node ID allocation server: payload types, register
// indexes, controller states and command/status structs. No dependencies.
`default_nettype none
package nidalloc_pkg;
  localparam int TableEntries = 4;
  localparam int TeW = $clog2(TableEntries);
  localparam int UidBytes = 16;
  localparam int MaxStageBytes = 6;

  localparam logic [1:0] RegLocalId = 2'd0;
  localparam logic [1:0] RegTimeout = 2'd1;
  localparam logic [1:0] RegMaxId = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  src_id;
    logic        first_part;
    logic [6:0]  preferred_id;
    logic [4:0]  chunk_len;
    logic [47:0] chunk_bytes;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  resp_node_id;
    logic [4:0]  resp_uid_len;
    logic        chunk_index;
    logic [63:0] uid_chunk;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StStage, StMatch, StSearch, StEmit0, StEmit1
  } state_e;

  typedef struct packed {
    logic load;
    logic stage;
    logic match;
    logic search_step;
    logic commit;
    logic clear_coll;
    logic emit_hi;
  } cmd_t;

  typedef struct packed {
    logic seen_only;
    logic drop;
    logic partial;
    logic hit;
    logic search_done;
    logic pick_ok;
    logic two_results;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/nidalloc_ctrl.sv */
// Controller state machine of the node ID allocation server.
// Depends on nidalloc_pkg and the assertion macro header.
`default_nettype none
`include "can_node_id_allocation_server_top_defines.svh"
module nidalloc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire nidalloc_pkg::sts_t sts_i,
  output nidalloc_pkg::cmd_t      cmd_o
);
  nidalloc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= nidalloc_pkg::StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nidalloc_pkg::StIdle: if (in_valid_i) state_d = nidalloc_pkg::StStage;
      nidalloc_pkg::StStage: begin
        if (sts_i.seen_only || sts_i.drop) state_d = nidalloc_pkg::StIdle;
        else if (sts_i.partial) state_d = nidalloc_pkg::StEmit0;
        else state_d = nidalloc_pkg::StMatch;
      end
      nidalloc_pkg::StMatch: state_d = sts_i.hit ? nidalloc_pkg::StEmit0
                                                 : nidalloc_pkg::StSearch;
      nidalloc_pkg::StSearch:
        if (sts_i.search_done)
          state_d = sts_i.pick_ok ? nidalloc_pkg::StEmit0 : nidalloc_pkg::StIdle;
      nidalloc_pkg::StEmit0:
        if (!out_stall_i)
          state_d = sts_i.two_results ? nidalloc_pkg::StEmit1 : nidalloc_pkg::StIdle;
      nidalloc_pkg::StEmit1: if (!out_stall_i) state_d = nidalloc_pkg::StIdle;
      default: state_d = nidalloc_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      nidalloc_pkg::StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      nidalloc_pkg::StStage: cmd_o.stage = 1'b1;
      nidalloc_pkg::StMatch: cmd_o.match = 1'b1;
      nidalloc_pkg::StSearch: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.search_done) begin
          cmd_o.commit = sts_i.pick_ok;
          cmd_o.clear_coll = 1'b1;
        end
      end
      nidalloc_pkg::StEmit0: out_valid_o = 1'b1;
      nidalloc_pkg::StEmit1: begin
        out_valid_o = 1'b1;
        cmd_o.emit_hi = 1'b1;
      end
      default: ;
    endcase
  end

  `NIA_ASSERT(a_emit_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)
  `NIA_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != nidalloc_pkg::StIdle) |-> in_stall_o)
  `NIA_ASSERT(a_commit_search, clk_i, rst_ni, cmd_o.commit |-> (state_q == nidalloc_pkg::StSearch))
endmodule
`default_nettype wire

/* rtl/nidalloc_dp.sv */
// Datapath of the node ID allocation server: config registers, seen set,
// allocation table, collection buffer and the serial free-ID search.
// Depends on nidalloc_pkg and the assertion macro header.
`default_nettype none
`include "can_node_id_allocation_server_top_defines.svh"
module nidalloc_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [15:0]            cfg_wdata_i,
  input  wire nidalloc_pkg::in_item_t in_item_i,
  input  wire nidalloc_pkg::cmd_t     cmd_i,
  output nidalloc_pkg::sts_t          sts_o,
  output nidalloc_pkg::out_item_t     out_item_o
);
  localparam int TE = nidalloc_pkg::TableEntries;
  localparam int TW = nidalloc_pkg::TeW;

  logic [6:0]  local_id_q, max_id_q;
  logic [15:0] timeout_q;
  logic [127:0] seen_q;
  logic [TE-1:0] used_q;
  logic [6:0]  ent_id_q [TE];
  logic [127:0] ent_uid_q [TE];
  logic [7:0]  buf_q [16];
  logic [4:0]  coll_q;
  logic [6:0]  pref_q;
  logic [31:0] last_t_q;
  nidalloc_pkg::in_item_t it_q;
  logic [6:0]  node_q, cand_q, pick_q;
  logic [4:0]  rlen_q;
  logic        pref_chk_q;

  // stage evaluation
  logic [4:0] base_len;
  logic [5:0] sum_len;
  logic       bad_len, stray;
  logic [31:0] dt;
  always_comb begin
    bad_len = (it_q.chunk_len == 5'd0) || (it_q.chunk_len > 5'(nidalloc_pkg::MaxStageBytes));
    dt = it_q.now_ms - last_t_q;
    stray = !it_q.first_part && ((coll_q == 5'd0) || (dt > {16'd0, timeout_q}));
    base_len = it_q.first_part ? 5'd0 : coll_q;
    sum_len = {1'b0, base_len} + {1'b0, it_q.chunk_len};
  end

  logic seen_only, drop;
  assign seen_only = it_q.src_id != 7'd0;
  assign drop = !seen_only && (it_q.req_type != 1'b1 || bad_len || stray || sum_len > 6'd16);

  // table match
  logic [127:0] uid_full;
  logic         hit;
  logic [6:0]   hit_id;
  logic         has_free;
  logic [TW-1:0] free_idx;
  always_comb begin
    for (int b = 0; b < 16; b++) uid_full[8*b +: 8] = buf_q[b];
    hit = 1'b0;
    hit_id = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = TE - 1; i >= 0; i--) begin
      if (used_q[i] && ent_uid_q[i] == uid_full) begin
        hit = 1'b1;
        hit_id = ent_id_q[i];
      end
      if (!used_q[i]) begin
        has_free = 1'b1;
        free_idx = TW'(i);
      end
    end
  end

  // in-use test of the candidate
  logic [6:0] test_id;
  logic       in_use;
  assign test_id = pref_chk_q ? pref_q : cand_q;
  always_comb begin
    in_use = (test_id == local_id_q) || seen_q[test_id];
    for (int i = 0; i < TE; i++)
      if (used_q[i] && ent_id_q[i] == test_id) in_use = 1'b1;
  end

  logic found, exhausted;
  assign found = pref_chk_q ? (pref_q != 7'd0 && pref_q <= max_id_q && !in_use)
                            : (cand_q != 7'd0 && !in_use);
  assign exhausted = !pref_chk_q && cand_q == 7'd0;

  assign sts_o.seen_only = seen_only;
  assign sts_o.drop = drop;
  assign sts_o.partial = sum_len < 6'd16;
  assign sts_o.hit = hit;
  assign sts_o.search_done = found || exhausted;
  assign sts_o.pick_ok = found && has_free;
  assign sts_o.two_results = rlen_q > 5'd8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= 7'd1;
      timeout_q  <= 16'd500;
      max_id_q   <= 7'd125;
      seen_q     <= '0;
      used_q     <= '0;
      coll_q     <= '0;
      pref_q     <= '0;
      last_t_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nidalloc_pkg::RegLocalId: local_id_q <= cfg_wdata_i[6:0];
          nidalloc_pkg::RegTimeout: timeout_q <= cfg_wdata_i;
          nidalloc_pkg::RegMaxId:   max_id_q <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.stage) begin
        if (seen_only) seen_q[it_q.src_id] <= 1'b1;
        else if (it_q.req_type && !bad_len) begin
          if (stray || sum_len > 6'd16) coll_q <= '0;
          else begin
            if (it_q.first_part) pref_q <= it_q.preferred_id;
            coll_q <= sum_len[4:0];
            last_t_q <= it_q.now_ms;
          end
        end
      end
      if (cmd_i.match && hit) coll_q <= '0;
      if (cmd_i.clear_coll) coll_q <= '0;
      if (cmd_i.commit) used_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_item_i;
    if (cmd_i.stage && !drop && !seen_only) begin
      for (int k = 0; k < nidalloc_pkg::MaxStageBytes; k++)
        if (5'(k) < it_q.chunk_len)
          buf_q[4'(base_len + 5'(k))] <= it_q.chunk_bytes[8*k +: 8];
      rlen_q <= sum_len[4:0];
      node_q <= '0;
    end
    if (cmd_i.match) begin
      node_q <= hit_id;
      pref_chk_q <= 1'b1;
      cand_q <= max_id_q;
    end
    if (cmd_i.search_step && !sts_o.search_done) begin
      if (pref_chk_q) pref_chk_q <= 1'b0;
      else cand_q <= cand_q - 7'd1;
    end
    if (cmd_i.commit) begin
      ent_id_q[free_idx] <= test_id;
      ent_uid_q[free_idx] <= uid_full;
      node_q <= test_id;
      pick_q <= test_id;
    end
  end

  // output
  always_comb begin
    logic [4:0] avail;
    logic       hi;
    hi = cmd_i.emit_hi;
    avail = hi ? (rlen_q - 5'd8) : ((rlen_q > 5'd8) ? 5'd8 : rlen_q);
    out_item_o.resp_node_id = node_q;
    out_item_o.resp_uid_len = rlen_q;
    out_item_o.chunk_index = hi;
    out_item_o.last = hi || rlen_q <= 5'd8;
    for (int b = 0; b < 8; b++)
      out_item_o.uid_chunk[8*b +: 8] = (5'(b) < avail) ? buf_q[{hi, 3'(b)}] : 8'd0;
  end

  `NIA_ASSERT(a_coll_range, clk_i, rst_ni, coll_q <= 5'd16)
  `NIA_ASSERT(a_commit_free, clk_i, rst_ni, cmd_i.commit |-> !used_q[free_idx])
  `NIA_ASSERT(a_commit_pick, clk_i, rst_ni, cmd_i.commit |=> (node_q == pick_q))
endmodule
`default_nettype wire

/* rtl/can_node_id_allocation_server_top.sv */
// Node ID allocation server for a CAN bus.
// Input channel: in_valid_i / in_stall_o with in_item_i; output channel:
// out_valid_o / out_stall_i with out_item_o (one or two items per response).
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i (0 local id, 1 timeout,
// 2 max id); writes take effect at once, no read-back.
// Flow: an item is registered on accept, evaluated next cycle. Items
// that give no response return to idle. A partial ID is echoed with no
// match or search. A complete ID goes to the table match and, on a miss,
// to the free-ID search, one candidate per cycle from the preferred ID and
// then down from max id. A hit or a pick yields one or two output items.
// One item is processed at a time; in_stall_o is high while busy.
// A stalled output item holds its payload until taken and blocks the next
// input item.
// Reset (rst_ni low) clears seen set, table, collection and restores the
// registers to local id 1, timeout 500 ms, max id 125.
// Depends on nidalloc_pkg, nidalloc_ctrl and nidalloc_dp.
`default_nettype none
module can_node_id_allocation_server_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [15:0]             cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire nidalloc_pkg::in_item_t  in_item_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output nidalloc_pkg::out_item_t      out_item_o
);
  nidalloc_pkg::cmd_t cmd;
  nidalloc_pkg::sts_t sts;

  nidalloc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  nidalloc_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .in_item_i,
    .cmd_i(cmd), .sts_o(sts), .out_item_o
  );
endmodule
`default_nettype wire
